### rtl/edf_pkg.sv
// Package for the earliest-deadline-first tick scheduler.
// Holds sizes, slot status codes, controller states and the structs passed between cells.
// No dependencies.
package edf_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
    localparam int TIME_BITS  = 16;
    localparam int CNT_BITS   = 5;
    localparam int LABEL_BITS = 8;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [CNT_BITS-1:0]   count_t;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_READY   = 2'd1,
        ST_DONE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE   = 2'd0,
        CTL_SCAN   = 2'd1,
        CTL_FINISH = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic   valid;
        logic   found;
        logic   nd_other;
        slot_t  best_slot;
        time_t  deadline;
        time_t  executed;
        time_t  length;
        time_t  arrival;
        label_t label;
    } token_t;

    typedef struct packed {
        logic   valid;
        slot_t  slot;
        time_t  arrival;
        time_t  length;
        time_t  deadline;
        label_t label;
    } load_t;

    typedef struct packed {
        logic  valid;
        slot_t slot;
        time_t executed;
        logic  done;
    } wb_t;

    typedef struct packed {
        time_t  current_time;
        logic   idle;
        slot_t  running_slot;
        label_t running_name;
        logic   finished;
        logic   missed;
        time_t  turnaround;
        logic   all_done;
    } result_t;

endpackage

### rtl/edf_cmd_if.sv
// Command channel of the scheduler: load and tick beats with valid and ready.
// Depends on edf_pkg.
interface edf_cmd_if;
    import edf_pkg::*;

    logic   valid;
    logic   ready;
    logic   func;
    slot_t  slot;
    time_t  arrival_time;
    time_t  run_length;
    time_t  deadline_time;
    label_t process_name;

    modport source (output valid, func, slot, arrival_time, run_length, deadline_time,
                    process_name, input ready);
    modport sink (input valid, func, slot, arrival_time, run_length, deadline_time,
                  process_name, output ready);
endinterface

### rtl/edf_result_if.sv
// Result channel of the scheduler: one beat per tick with valid and ready.
// Depends on edf_pkg.
interface edf_result_if;
    import edf_pkg::*;

    logic   valid;
    logic   ready;
    time_t  current_time;
    logic   idle;
    slot_t  running_slot;
    label_t running_name;
    logic   finished;
    logic   missed;
    time_t  turnaround;
    logic   all_done;

    modport source (output valid, current_time, idle, running_slot, running_name, finished,
                    missed, turnaround, all_done, input ready);
    modport sink (input valid, current_time, idle, running_slot, running_name, finished,
                  missed, turnaround, all_done, output ready);
endinterface

### rtl/edf_cell.sv
// One process slot of the scheduler chain: slot state plus one stage of the scan token.
// Depends on edf_pkg.
module edf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  edf_pkg::slot_t  index,
    input  logic            active,
    input  edf_pkg::time_t  now,
    input  edf_pkg::load_t  ld,
    input  edf_pkg::wb_t    wb,
    input  edf_pkg::token_t tok_in,
    output edf_pkg::token_t tok_out
);
    import edf_pkg::*;

    time_t   arrival_reg;
    time_t   length_reg;
    time_t   deadline_reg;
    label_t  label_reg;
    time_t   executed_reg;
    time_t   executed_next;
    status_t status_reg;
    status_t status_next;
    status_t status_arr;
    token_t  tok_reg;
    token_t  tok_next;
    logic    tok_valid_reg;
    logic    take;

    always_comb
    begin
        status_arr = status_reg;
        if (tok_in.valid && active && status_reg == ST_PENDING && arrival_reg == now)
        begin
            status_arr = ST_READY;
        end
    end

    always_comb
    begin
        take = tok_in.valid && active && status_arr == ST_READY &&
               (!tok_in.found || deadline_reg < tok_in.deadline);
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found     = 1'b1;
            tok_next.nd_other  = tok_in.nd_other | tok_in.found;
            tok_next.best_slot = index;
            tok_next.deadline  = deadline_reg;
            tok_next.executed  = executed_reg;
            tok_next.length    = length_reg;
            tok_next.arrival   = arrival_reg;
            tok_next.label     = label_reg;
        end
        else if (active && status_arr != ST_DONE)
        begin
            tok_next.nd_other = 1'b1;
        end
    end

    always_comb
    begin
        status_next   = status_reg;
        executed_next = executed_reg;
        if (ld.valid && ld.slot == index)
        begin
            status_next   = ST_PENDING;
            executed_next = '0;
        end
        else if (wb.valid && wb.slot == index)
        begin
            executed_next = wb.executed;
            status_next   = wb.done ? ST_DONE : ST_READY;
        end
        else if (tok_in.valid)
        begin
            status_next = status_arr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_PENDING;
            executed_reg  <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            executed_reg  <= executed_next;
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.valid && ld.slot == index)
        begin
            arrival_reg  <= ld.arrival;
            length_reg   <= ld.length;
            deadline_reg <= ld.deadline;
            label_reg    <= ld.label;
        end
        if (tok_in.valid)
        begin
            tok_reg <= tok_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

### rtl/edf_finish.sv
// End of the scan chain: turns the winning token into the tick result and the slot update.
// Depends on edf_pkg.
module edf_finish (
    input  edf_pkg::token_t  tok,
    input  edf_pkg::time_t   now,
    output edf_pkg::result_t res,
    output edf_pkg::wb_t     wb
);
    import edf_pkg::*;

    time_t exec_inc;
    logic  fin;
    logic  miss;

    always_comb
    begin
        exec_inc = TIME_BITS'(tok.executed + 1'b1);
        fin      = tok.found && exec_inc == tok.length;
        miss     = tok.found && !fin && tok.deadline == now;

        res.current_time = now;
        res.idle         = !tok.found;
        res.running_slot = tok.found ? tok.best_slot : '0;
        res.running_name = tok.found ? tok.label : '0;
        res.finished     = fin;
        res.missed       = miss;
        res.turnaround   = fin ? TIME_BITS'(now - tok.arrival + 1'b1) : '0;
        res.all_done     = !tok.nd_other && (!tok.found || fin || miss);

        wb.valid    = tok.found;
        wb.slot     = tok.best_slot;
        wb.executed = exec_inc;
        wb.done     = fin || miss;
    end

endmodule

### rtl/edf_tick_scheduler.sv
// Top level of the earliest-deadline-first tick scheduler.
// Depends on edf_pkg, edf_cmd_if, edf_result_if, edf_cell and edf_finish.
//
// The cmd channel takes load beats (func 0) and tick beats (func 1). A load beat
// writes one slot and gives no result. A tick beat sends a scan token down the
// row of sixteen slot cells, one cell per cycle; each cell marks its process ready
// on arrival and keeps the earliest deadline in the token. When the token has left
// the last cell, the controller enters its finish state; there, once the output
// register is free, the winner is updated and the result beat is written to the
// output register. The cmd channel takes its next beat in the cycle after that.
// The cmd channel is ready whenever no tick is in flight, so the next beat is taken
// while a result still waits. If the receiver stalls, the following tick holds in
// its last step until the waiting result is taken.
// cfg_we writes process_count from cfg_wdata; the user must write it only
// while idle, and the block does not enforce this.
// Reset clears the time, the run counts, all slot states to pending and sets
// process_count to 1; slot parameters are undefined until loaded.
module edf_tick_scheduler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  edf_pkg::count_t   cfg_wdata,
    edf_cmd_if.sink           cmd,
    edf_result_if.source      result
);
    import edf_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    count_t     count_reg;
    time_t      tick_time_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    result_t    res_comb;
    wb_t        wb_comb;
    wb_t        wb;
    load_t      ld;
    token_t     tok [0:MAX_SLOTS];
    logic [MAX_SLOTS-1:0] tok_valid_vec;
    logic       accept;
    logic       start;
    logic       fire;

    assign accept = cmd.valid && cmd.ready;
    assign start  = accept && cmd.func;
    assign fire   = state_reg == CTL_FINISH && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (start)
                begin
                    state_next = CTL_SCAN;
                end
            end
            CTL_SCAN:
            begin
                if (tok[MAX_SLOTS].valid)
                begin
                    state_next = CTL_FINISH;
                end
            end
            CTL_FINISH:
            begin
                if (fire)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready = state_reg == CTL_IDLE;

        ld.valid    = accept && !cmd.func;
        ld.slot     = cmd.slot;
        ld.arrival  = cmd.arrival_time;
        ld.length   = cmd.run_length;
        ld.deadline = cmd.deadline_time;
        ld.label    = cmd.process_name;

        tok[0]          = '0;
        tok[0].valid    = start;

        wb       = wb_comb;
        wb.valid = wb_comb.valid && fire;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_cell
            localparam slot_t  IDX  = SLOT_BITS'(g);
            localparam count_t CIDX = CNT_BITS'(g);
            edf_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .index   (IDX),
                .active  (CIDX < count_reg),
                .now     (tick_time_reg),
                .ld      (ld),
                .wb      (wb),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
            assign tok_valid_vec[g] = tok[g+1].valid;
        end
    endgenerate

    edf_finish u_finish (
        .tok (tok[MAX_SLOTS]),
        .now (tick_time_reg),
        .res (res_comb),
        .wb  (wb_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            count_reg     <= count_t'(1);
            tick_time_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (fire)
            begin
                tick_time_reg <= TIME_BITS'(tick_time_reg + 1'b1);
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.current_time = res_reg.current_time;
    assign result.idle         = res_reg.idle;
    assign result.running_slot = res_reg.running_slot;
    assign result.running_name = res_reg.running_name;
    assign result.finished     = res_reg.finished;
    assign result.missed       = res_reg.missed;
    assign result.turnaround   = res_reg.turnaround;
    assign result.all_done     = res_reg.all_done;

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_valid_vec))
        else $error("More than one scan token is in the cell chain.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid_vec != '0) |-> state_reg == CTL_SCAN)
        else $error("A scan token is moving outside of a scan.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == CTL_FINISH))
        else $error("A result beat appeared without a finished scan.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tick_time_reg) |-> $past(fire))
        else $error("The tick time moved without a completed tick.");

endmodule
